[rtl/btkh_pkg.sv]
`default_nettype none
package btkh_pkg;

	localparam int DEF_HEAP_DEPTH = 1024;
	localparam int DEF_KEY_WIDTH  = 64;

	localparam int CFG_DATA_W  = 11;
	localparam int COUNT_OUT_W = 11;
	localparam int THRESH_W    = 64;

	localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 11'd1024;

	typedef enum logic [0:0] {
		CFG_KEEP_LIMIT    = 1'b0,
		CFG_KEEP_SMALLEST = 1'b1
	} cfg_index_t;

	// true when a must sit below b: a is the better key
	function automatic logic key_before(input logic signed [THRESH_W-1:0] a,
		input logic signed [THRESH_W-1:0] b, input logic smallest);
		logic res;
		if (smallest) begin
			res = (a < b);
		end else begin
			res = (a > b);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

[rtl/btkh_ram.sv]
`default_nettype none
module btkh_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64,
	parameter int AW    = 10
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr_a,
	input  wire logic [AW-1:0]    rd_addr_b,
	output logic      [WIDTH-1:0] rd_data_a,
	output logic      [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule
`default_nettype wire

[rtl/bounded_topk_heap_threshold.sv]
// a key that leaves the heap alone goes straight to the finish state, where result_valid is raised;
// a push reads and compares the parent for each level it climbs, until it stops or reaches the root;
// a root replacement reads and compares the children for each level it sinks, until it stops
// throughput: one key at a time, the next can be taken while result_valid is high;
// set by the single heap memory walked one level at a time, a stalled result holds the finish state
// reset: count cleared, limit 1024, smallest keys kept; heap memory is not cleared
`default_nettype none
module bounded_topk_heap_threshold #(
	parameter int HEAP_DEPTH = btkh_pkg::DEF_HEAP_DEPTH,
	parameter int KEY_WIDTH  = btkh_pkg::DEF_KEY_WIDTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic                                 cfg_index,
	input  wire logic [btkh_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 key_valid,
	output logic                                      key_stall,
	input  wire logic signed [KEY_WIDTH-1:0]          key,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic signed [btkh_pkg::THRESH_W-1:0]      threshold,
	output logic [btkh_pkg::COUNT_OUT_W-1:0]          kept_count,
	output logic                                      heap_full
);
	import btkh_pkg::*;

	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int IW = AW + 2;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_UP_RD  = 6'b000010,
		ST_UP_CMP = 6'b000100,
		ST_DN_CHK = 6'b001000,
		ST_DN_CMP = 6'b010000,
		ST_FIN    = 6'b100000
	} state_t;

	state_t state_q;

	logic [CFG_DATA_W-1:0]       keep_limit_q;
	logic                        keep_smallest_q;
	logic [CW-1:0]               count_q;
	logic [AW-1:0]               pos_q;
	logic signed [KEY_WIDTH-1:0] v_q;
	logic signed [KEY_WIDTH-1:0] root_q;

	logic                        res_valid_q;
	logic signed [THRESH_W-1:0]  threshold_q;
	logic [COUNT_OUT_W-1:0]      kept_count_q;
	logic                        heap_full_q;

	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic signed [KEY_WIDTH-1:0] wr_data;
	logic [AW-1:0]               rd_addr_a;
	logic [AW-1:0]               rd_addr_b;
	logic signed [KEY_WIDTH-1:0] rd_data_a;
	logic signed [KEY_WIDTH-1:0] rd_data_b;

	logic [31:0]   lim32;
	logic [CW-1:0] eff_lim;
	logic [31:0]   cnt32;
	logic          accept;
	logic          push;
	logic          replace;
	logic [AW-1:0] parent;
	logic [IW-1:0] child;
	logic [IW-1:0] child_b;
	logic [IW-1:0] n_w;
	logic          has_b;
	logic          sel_b;
	logic signed [KEY_WIDTH-1:0] cval;
	logic          up_move;
	logic          dn_stop;
	logic          out_free;

	// effective limit: zero acts as one, clipped to the heap depth
	always_comb begin
		lim32 = 32'(keep_limit_q);
		if (lim32 == 32'd0) begin
			lim32 = 32'd1;
		end else if (lim32 > 32'(HEAP_DEPTH)) begin
			lim32 = 32'(HEAP_DEPTH);
		end
	end
	assign eff_lim = lim32[CW-1:0];
	assign cnt32   = 32'(count_q);

	assign key_stall = (state_q != ST_IDLE);
	assign accept    = key_valid && !key_stall;
	assign push      = (count_q < eff_lim);
	assign replace   = key_before(THRESH_W'(key), THRESH_W'(root_q), keep_smallest_q);

	assign parent  = (pos_q - AW'(1)) >> 1;
	assign child   = (IW'(pos_q) << 1) | IW'(1);
	assign child_b = child + IW'(1);
	assign n_w     = IW'(count_q);
	assign has_b   = (child_b < n_w);
	assign sel_b   = has_b && key_before(THRESH_W'(rd_data_a), THRESH_W'(rd_data_b),
		keep_smallest_q);
	assign cval    = sel_b ? rd_data_b : rd_data_a;
	assign up_move = key_before(THRESH_W'(rd_data_a), THRESH_W'(v_q), keep_smallest_q);
	assign dn_stop = key_before(THRESH_W'(cval), THRESH_W'(v_q), keep_smallest_q);
	assign out_free = !res_valid_q || !result_stall;

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = v_q;
		rd_addr_a = parent;
		rd_addr_b = child_b[AW-1:0];
		unique case (state_q)
			ST_UP_RD: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
				end
			end
			ST_UP_CMP: begin
				wr_en = 1'b1;
				if (up_move) begin
					wr_data = rd_data_a;
				end
			end
			ST_DN_CHK: begin
				rd_addr_a = child[AW-1:0];
				if (child >= n_w) begin
					wr_en = 1'b1;
				end
			end
			ST_DN_CMP: begin
				wr_en = 1'b1;
				if (!dn_stop) begin
					wr_data = cval;
				end
			end
			ST_IDLE, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	btkh_ram #(
		.DEPTH (HEAP_DEPTH),
		.WIDTH (KEY_WIDTH),
		.AW    (AW)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_limit_q    <= LIMIT_RESET;
			keep_smallest_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_KEEP_LIMIT:    keep_limit_q    <= cfg_data;
				CFG_KEEP_SMALLEST: keep_smallest_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// root copy follows every write to the top entry
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == '0)) begin
			root_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (push) begin
							count_q <= count_q + CW'(1);
							state_q <= ST_UP_RD;
						end else if (replace) begin
							state_q <= ST_DN_CHK;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_UP_RD: begin
					state_q <= (pos_q == '0) ? ST_FIN : ST_UP_CMP;
				end
				ST_UP_CMP: begin
					state_q <= up_move ? ST_UP_RD : ST_FIN;
				end
				ST_DN_CHK: begin
					state_q <= (child >= n_w) ? ST_FIN : ST_DN_CMP;
				end
				ST_DN_CMP: begin
					state_q <= dn_stop ? ST_FIN : ST_DN_CHK;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					v_q   <= key;
					pos_q <= push ? count_q[AW-1:0] : '0;
				end
			end
			ST_UP_CMP: begin
				if (up_move) begin
					pos_q <= parent;
				end
			end
			ST_DN_CMP: begin
				if (!dn_stop) begin
					pos_q <= sel_b ? child_b[AW-1:0] : child[AW-1:0];
				end
			end
			ST_FIN: begin
				if (out_free) begin
					threshold_q  <= THRESH_W'(root_q);
					kept_count_q <= cnt32[COUNT_OUT_W-1:0];
					heap_full_q  <= (count_q >= eff_lim);
				end
			end
			ST_UP_RD, ST_DN_CHK: begin
			end
			default: begin
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign threshold    = threshold_q;
	assign kept_count   = kept_count_q;
	assign heap_full    = heap_full_q;

endmodule
`default_nettype wire
